/* sv/sdam_pkg.sv */
// ----------------------------------------------------------------------------
// sdam_pkg
// Shared widths, codes and types of the start delay average monitor.
// ----------------------------------------------------------------------------
package sdam_pkg;

  localparam int CHANNELS_DEFAULT = 32;
  localparam int HISTORY_DEPTH    = 5;
  localparam int DELAY_W          = 15;
  localparam int CHAN_W           = 5;
  localparam int ELAPSED_W        = 8;
  localparam int WIN_W            = 3;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 15;

  // sum of five 15-bit delays fits in 18 bits
  localparam int SUM_W            = 18;
  // shared adder width, wide enough for signed differences
  localparam int ALU_W            = 20;

  localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

  // opcodes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_INIT   = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_CHECK_EN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVIATION_TRK_EN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY    = 3'd4;

  typedef logic [DELAY_W-1:0] delay_t;

  // one channel's stored state, kept as a single memory row
  typedef struct packed {
    delay_t [HISTORY_DEPTH-1:0] hist;
    delay_t                     running;
    delay_t                     average;
    delay_t                     err_count;
    delay_t                     excess;
  } chan_row_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SUM,
    ST_DIV,
    ST_HI,
    ST_CHK_HI,
    ST_LO,
    ST_CHK_LO,
    ST_UPD,
    ST_WRITE
  } state_t;

endpackage

/* sv/sdam_intf.sv */
// ----------------------------------------------------------------------------
// sdam channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface sdam_item_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [sdam_pkg::CHAN_W-1:0]    channel;
  logic                           start_green;
  logic                           green;
  logic                           feedback_red;
  logic                           feedback_green;
  logic [sdam_pkg::ELAPSED_W-1:0] elapsed;

  modport source (
    output valid, opcode, channel, start_green, green, feedback_red,
           feedback_green, elapsed,
    input  ready
  );
  modport sink (
    input  valid, opcode, channel, start_green, green, feedback_red,
           feedback_green, elapsed,
    output ready
  );
endinterface

interface sdam_result_if;
  logic                         valid;
  logic                         ready;
  logic [sdam_pkg::CHAN_W-1:0]  out_channel;
  logic [sdam_pkg::DELAY_W-1:0] latest_delay;
  logic [sdam_pkg::DELAY_W-1:0] average_delay;
  logic                         sample_taken;
  logic                         deviation_error;
  logic [sdam_pkg::DELAY_W-1:0] error_count;
  logic [sdam_pkg::DELAY_W-1:0] max_excess;

  modport source (
    output valid, out_channel, latest_delay, average_delay, sample_taken,
           deviation_error, error_count, max_excess,
    input  ready
  );
  modport sink (
    input  valid, out_channel, latest_delay, average_delay, sample_taken,
           deviation_error, error_count, max_excess,
    output ready
  );
endinterface

interface sdam_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sdam_pkg::CFG_IDX_W-1:0]  index;
  logic [sdam_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/sdam_ram.sv */
// ----------------------------------------------------------------------------
// sdam_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sdam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/start_delay_average_monitor.sv */
// ----------------------------------------------------------------------------
// start_delay_average_monitor
// Per-channel green start delay history, windowed average and deviation check.
// ----------------------------------------------------------------------------
// Path from item accepted to result valid: a channel beyond range goes straight
// to write-back; init or an update without a completed sample passes load and
// write-back; a completed sample adds the sum over N entries, division (only
// when all N entries are nonzero) and, when enabled, the deviation check.
// Items are accepted only in idle, so the next item waits until the result is handed over.
// Reset restores the register defaults and marks every channel row as zero.
module start_delay_average_monitor #(
  parameter int CHANNELS = sdam_pkg::CHANNELS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  sdam_item_if.sink     items,
  sdam_result_if.source results,
  sdam_cfg_if.sink      cfg
);

  localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W   = $clog2(sdam_pkg::SUM_W);
  localparam int ROW_W   = $bits(sdam_pkg::chan_row_t);
  localparam int HD      = sdam_pkg::HISTORY_DEPTH;
  localparam int DW      = sdam_pkg::DELAY_W;
  localparam int AW      = sdam_pkg::ALU_W;
  localparam int SW      = sdam_pkg::SUM_W;
  localparam int WW      = sdam_pkg::WIN_W;
  localparam logic [8:0] CH_LIMIT = 9'(CHANNELS);

  // clamp the window length to 1..history depth
  function automatic logic [WW-1:0] clamp_window(input logic [WW-1:0] w);
    logic [WW-1:0] n;
    if (w > WW'(HD)) begin
      n = WW'(HD);
    end else if (w == '0) begin
      n = WW'(1);
    end else begin
      n = w;
    end
    return n;
  endfunction

  // configuration registers
  logic [WW-1:0]        window_length;
  sdam_pkg::delay_t     tolerance;
  logic                 error_check_enable;
  logic                 deviation_track_enable;
  sdam_pkg::delay_t     initial_delay;

  // captured item
  logic                 opcode;
  logic [sdam_pkg::CHAN_W-1:0]    channel;
  logic                 start_green;
  logic                 green;
  logic                 feedback_red;
  logic                 feedback_green;
  logic [sdam_pkg::ELAPSED_W-1:0] elapsed;
  logic                 out_of_range;
  logic                 row_hit;

  // sequencer and working registers
  sdam_pkg::state_t     state, state_next;
  sdam_pkg::delay_t [HD-1:0] hist, hist_next;
  sdam_pkg::delay_t     running, running_next;
  sdam_pkg::delay_t     average, average_next;
  sdam_pkg::delay_t     err_count, err_count_next;
  sdam_pkg::delay_t     excess, excess_next;
  sdam_pkg::delay_t     excess_new, excess_new_next;
  logic                 taken, taken_next;
  logic                 dev_err, dev_err_next;
  logic [AW-1:0]        acc, acc_next;
  logic [2:0]           idx, idx_next;
  logic [WW-1:0]        win_n, win_n_next;
  logic                 all_nz, all_nz_next;
  logic [CNT_W-1:0]     div_cnt, div_cnt_next;
  logic [2:0]           rem, rem_next;
  logic [SW-1:0]        dq, dq_next;

  // shared adder / subtractor
  logic [AW-1:0]        alu_a, alu_b, alu_res;
  logic                 alu_sub;

  // memory and valid bits
  logic [CHANNELS-1:0]  row_valid;
  logic                 ram_we;
  logic [IDX_W-1:0]     in_addr, cur_addr;
  logic [ROW_W-1:0]     ram_rdata;
  sdam_pkg::chan_row_t  row, wrow;

  logic                 accept;
  logic                 in_range;
  logic                 out_free;
  logic [8:0]           in_ch_ext, cur_ch_ext;
  sdam_pkg::state_t     check_state;
  logic                 acc_cond;
  sdam_pkg::delay_t     run_upd;
  sdam_pkg::delay_t     first_delay;
  logic [3:0]           trial;
  logic                 trial_ge;
  logic                 sum_nz;

  assign accept     = items.valid && items.ready;
  assign items.ready = (state == sdam_pkg::ST_IDLE);
  assign cfg.ready  = 1'b1;
  assign in_ch_ext  = {4'b0, items.channel};
  assign cur_ch_ext = {4'b0, channel};
  assign in_range   = (in_ch_ext < CH_LIMIT);
  assign in_addr    = in_ch_ext[IDX_W-1:0];
  assign cur_addr   = cur_ch_ext[IDX_W-1:0];
  assign out_free   = !results.valid || results.ready;
  assign alu_res    = alu_a + (alu_b ^ {AW{alu_sub}}) + AW'(alu_sub);
  assign row        = row_hit ? sdam_pkg::chan_row_t'(ram_rdata) : '0;
  assign check_state = error_check_enable ? sdam_pkg::ST_HI : sdam_pkg::ST_WRITE;

  assign wrow.hist      = hist;
  assign wrow.running   = running;
  assign wrow.average   = average;
  assign wrow.err_count = err_count;
  assign wrow.excess    = excess;

  sdam_ram #(
    .WIDTH (ROW_W),
    .DEPTH (CHANNELS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_addr),
    .wdata (ROW_W'(wrow)),
    .re    (accept),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length          <= WW'(HD);
      tolerance              <= '0;
      error_check_enable     <= 1'b0;
      deviation_track_enable <= 1'b0;
      initial_delay          <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        sdam_pkg::CFG_WINDOW_LENGTH:    window_length <= cfg.data[WW-1:0];
        sdam_pkg::CFG_TOLERANCE:        tolerance <= cfg.data[DW-1:0];
        sdam_pkg::CFG_ERROR_CHECK_EN:   error_check_enable <= cfg.data[0];
        sdam_pkg::CFG_DEVIATION_TRK_EN: deviation_track_enable <= cfg.data[0];
        sdam_pkg::CFG_INITIAL_DELAY:    initial_delay <= cfg.data[DW-1:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      opcode         <= items.opcode;
      channel        <= items.channel;
      start_green    <= items.start_green;
      green          <= items.green;
      feedback_red   <= items.feedback_red;
      feedback_green <= items.feedback_green;
      elapsed        <= items.elapsed;
      out_of_range   <= !in_range;
      row_hit        <= in_range && row_valid[in_addr];
    end
  end

  // row valid bits: an unwritten row reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (ram_we) begin
      row_valid[cur_addr] <= 1'b1;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdam_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    hist       <= hist_next;
    running    <= running_next;
    average    <= average_next;
    err_count  <= err_count_next;
    excess     <= excess_next;
    excess_new <= excess_new_next;
    taken      <= taken_next;
    dev_err    <= dev_err_next;
    acc        <= acc_next;
    idx        <= idx_next;
    win_n      <= win_n_next;
    all_nz     <= all_nz_next;
    div_cnt    <= div_cnt_next;
    rem        <= rem_next;
    dq         <= dq_next;
  end

  // sequencer: next state, shared adder operands, working values
  always_comb begin
    state_next      = state;
    hist_next       = hist;
    running_next    = running;
    average_next    = average;
    err_count_next  = err_count;
    excess_next     = excess;
    excess_new_next = excess_new;
    taken_next      = taken;
    dev_err_next    = dev_err;
    acc_next        = acc;
    idx_next        = idx;
    win_n_next      = win_n;
    all_nz_next     = all_nz;
    div_cnt_next    = div_cnt;
    rem_next        = rem;
    dq_next         = dq;
    alu_a           = '0;
    alu_b           = '0;
    alu_sub         = 1'b0;
    ram_we          = 1'b0;
    acc_cond        = 1'b0;
    run_upd         = '0;
    first_delay     = '0;
    trial           = '0;
    trial_ge        = 1'b0;
    sum_nz          = 1'b0;

    unique case (state)
      sdam_pkg::ST_IDLE: begin
        if (accept) begin
          taken_next   = 1'b0;
          dev_err_next = 1'b0;
          state_next   = in_range ? sdam_pkg::ST_LOAD : sdam_pkg::ST_WRITE;
        end
      end

      // row data arrives; apply init or accumulate
      sdam_pkg::ST_LOAD: begin
        err_count_next = row.err_count;
        excess_next    = row.excess;
        if (opcode == sdam_pkg::OP_INIT) begin
          alu_a   = AW'(initial_delay);
          alu_b   = AW'(1);
          alu_sub = 1'b1;
          first_delay = (initial_delay > DW'(2)) ? alu_res[DW-1:0] : DW'(1);
          hist_next[0] = (window_length > WW'(1)) ? first_delay : '0;
          hist_next[1] = (window_length > WW'(2)) ? initial_delay : '0;
          hist_next[2] = (window_length > WW'(3)) ? initial_delay : '0;
          hist_next[3] = (window_length > WW'(4)) ? initial_delay : '0;
          hist_next[4] = '0;
          running_next = '0;
          average_next = '0;
          state_next   = sdam_pkg::ST_WRITE;
        end else begin
          alu_a    = AW'(row.running);
          alu_b    = AW'(elapsed);
          acc_cond = start_green || (green && feedback_red && (elapsed != '0));
          if (acc_cond) begin
            run_upd = (alu_res > AW'(sdam_pkg::DELAY_MAX)) ? sdam_pkg::DELAY_MAX
                                                           : alu_res[DW-1:0];
          end else begin
            run_upd = row.running;
          end
          average_next = row.average;
          if ((elapsed != '0) && feedback_green && (run_upd != '0)) begin
            hist_next[0] = run_upd;
            for (int i = 1; i < HD; i++) begin
              hist_next[i] = row.hist[i-1];
            end
            running_next = '0;
            taken_next   = 1'b1;
            acc_next     = '0;
            idx_next     = '0;
            all_nz_next  = 1'b1;
            win_n_next   = clamp_window(window_length);
            state_next   = sdam_pkg::ST_SUM;
          end else begin
            hist_next    = row.hist;
            running_next = run_upd;
            state_next   = sdam_pkg::ST_WRITE;
          end
        end
      end

      // add one history entry per cycle
      sdam_pkg::ST_SUM: begin
        alu_a       = acc;
        alu_b       = AW'(hist[idx]);
        acc_next    = alu_res;
        sum_nz      = all_nz && (hist[idx] != '0);
        all_nz_next = sum_nz;
        idx_next    = idx + 3'd1;
        if (idx == 3'(win_n - WW'(1))) begin
          if (sum_nz) begin
            dq_next      = alu_res[SW-1:0];
            rem_next     = '0;
            div_cnt_next = '0;
            state_next   = sdam_pkg::ST_DIV;
          end else begin
            state_next = check_state;
          end
        end
      end

      // restoring division by the window length, one quotient bit a cycle
      sdam_pkg::ST_DIV: begin
        trial    = {rem, dq[SW-1]};
        alu_a    = AW'(trial);
        alu_b    = AW'(win_n);
        alu_sub  = 1'b1;
        trial_ge = !alu_res[AW-1];
        rem_next = trial_ge ? alu_res[2:0] : trial[2:0];
        dq_next  = {dq[SW-2:0], trial_ge};
        div_cnt_next = div_cnt + CNT_W'(1);
        if (div_cnt == CNT_W'(SW - 1)) begin
          average_next = dq_next[DW-1:0];
          state_next   = check_state;
        end
      end

      // upper bound: average + tolerance
      sdam_pkg::ST_HI: begin
        alu_a      = AW'(average);
        alu_b      = AW'(tolerance);
        acc_next   = alu_res;
        state_next = sdam_pkg::ST_CHK_HI;
      end

      sdam_pkg::ST_CHK_HI: begin
        alu_a   = AW'(hist[0]);
        alu_b   = acc;
        alu_sub = 1'b1;
        if (!alu_res[AW-1] && (alu_res != '0)) begin
          excess_new_next = alu_res[DW-1:0];
          dev_err_next    = 1'b1;
          state_next      = sdam_pkg::ST_UPD;
        end else begin
          state_next = sdam_pkg::ST_LO;
        end
      end

      // lower bound: average - tolerance, may go negative
      sdam_pkg::ST_LO: begin
        alu_a      = AW'(average);
        alu_b      = AW'(tolerance);
        alu_sub    = 1'b1;
        acc_next   = alu_res;
        state_next = sdam_pkg::ST_CHK_LO;
      end

      sdam_pkg::ST_CHK_LO: begin
        alu_a   = acc;
        alu_b   = AW'(hist[0]);
        alu_sub = 1'b1;
        if (!alu_res[AW-1] && (alu_res != '0)) begin
          excess_new_next = alu_res[DW-1:0];
          dev_err_next    = 1'b1;
          state_next      = sdam_pkg::ST_UPD;
        end else begin
          state_next = sdam_pkg::ST_WRITE;
        end
      end

      // saturating error count and largest excess
      sdam_pkg::ST_UPD: begin
        alu_a = AW'(err_count);
        alu_b = AW'(1);
        err_count_next = (err_count == sdam_pkg::DELAY_MAX) ? err_count
                                                            : alu_res[DW-1:0];
        if (deviation_track_enable && (excess_new > excess)) begin
          excess_next = excess_new;
        end
        state_next = sdam_pkg::ST_WRITE;
      end

      // write back and hand the result over
      sdam_pkg::ST_WRITE: begin
        if (out_free) begin
          ram_we     = !out_of_range;
          state_next = sdam_pkg::ST_IDLE;
        end
      end

      default: state_next = sdam_pkg::ST_IDLE;
    endcase
  end

  // result register: valid
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if ((state == sdam_pkg::ST_WRITE) && out_free) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  // result register: payload
  always_ff @(posedge clk) begin
    if ((state == sdam_pkg::ST_WRITE) && out_free) begin
      results.out_channel <= channel;
      if (out_of_range) begin
        results.latest_delay    <= '0;
        results.average_delay   <= '0;
        results.sample_taken    <= 1'b0;
        results.deviation_error <= 1'b0;
        results.error_count     <= '0;
        results.max_excess      <= '0;
      end else begin
        results.latest_delay    <= hist[0];
        results.average_delay   <= average;
        results.sample_taken    <= taken;
        results.deviation_error <= dev_err;
        results.error_count     <= err_count;
        results.max_excess      <= excess;
      end
    end
  end

  // checks
  a_we_only_in_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == sdam_pkg::ST_WRITE) && !out_of_range)
    else $error("row written outside write-back or for a channel out of range");

  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == sdam_pkg::ST_LOAD) || (state == sdam_pkg::ST_WRITE))
    else $error("accepted item did not enter load or write-back");

  a_err_needs_sample: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.deviation_error |-> results.sample_taken)
    else $error("deviation error reported without a completed sample");

  a_sum_index: assert property (@(posedge clk) disable iff (rst)
    (state == sdam_pkg::ST_SUM) |-> (idx < 3'(win_n)) && (win_n != '0))
    else $error("history sum index beyond window");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == sdam_pkg::ST_DIV) |-> (div_cnt < CNT_W'(SW)))
    else $error("divider step count overrun");

endmodule

/* test/start_delay_average_monitor_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// start_delay_average_monitor_chk
// Watches the configuration, item and result channels of the start delay
// average monitor. Keeps its own copy of every channel's delay history and
// counters, works out the result of each accepted item and checks the results
// that leave the block, in order, field by field.
// ----------------------------------------------------------------------------
module start_delay_average_monitor_chk
  import sdam_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  sdam_item_if   items,
  sdam_result_if results,
  sdam_cfg_if    cfg,
  output int     fail_count,
  output int     pending
);

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    delay_t            latest;
    delay_t            average;
    logic              taken;
    logic              err;
    delay_t            count;
    delay_t            excess;
  } monitor_report_t;

  // shadow of the configuration registers
  logic [WIN_W-1:0] win_len;
  delay_t           tol;
  logic             chk_en;
  logic             trk_en;
  delay_t           init_delay;

  // shadow of the per-channel state, entry 0 is the newest delay
  delay_t history    [CHANNELS][HISTORY_DEPTH];
  delay_t running    [CHANNELS];
  delay_t avg        [CHANNELS];
  delay_t err_cnt    [CHANNELS];
  delay_t excess_max [CHANNELS];

  monitor_report_t due_reports [$];
  int              mismatches;

  // init opcode: preload the history from initial_delay, gated by raw window
  function automatic void seed_channel(int c);
    delay_t first;
    first = (init_delay > 2) ? init_delay - 1'b1 : delay_t'(1);
    history[c][0] = (win_len > 1) ? first : '0;
    history[c][1] = (win_len > 2) ? init_delay : '0;
    history[c][2] = (win_len > 3) ? init_delay : '0;
    history[c][3] = (win_len > 4) ? init_delay : '0;
    history[c][HISTORY_DEPTH-1] = '0;
    running[c] = '0;
    avg[c]     = '0;
  endfunction

  // feedback confirmed green: shift the delay in, average, check deviation
  function automatic logic close_sample(int c);
    int   n;
    int   i;
    int   sum;
    logic all_set;
    int   d;
    int   hi;
    int   lo;
    int   over;
    n = int'(win_len);
    if (n > HISTORY_DEPTH) n = HISTORY_DEPTH;
    if (n < 1) n = 1;
    for (i = HISTORY_DEPTH - 1; i > 0; i--) history[c][i] = history[c][i-1];
    history[c][0] = running[c];
    sum = 0;
    all_set = 1'b1;
    for (i = 0; i < n; i++) begin
      if (history[c][i] == '0) all_set = 1'b0;
      sum += int'(history[c][i]);
    end
    if (all_set) avg[c] = delay_t'(sum / n);
    running[c] = '0;
    if (!chk_en) return 1'b0;
    d  = int'(history[c][0]);
    hi = int'(avg[c]) + int'(tol);
    lo = int'(avg[c]) - int'(tol);
    if (d > hi || d < lo) begin
      if (err_cnt[c] < DELAY_MAX) err_cnt[c] = err_cnt[c] + 1'b1;
      // lower side counts from average minus tolerance
      over = (d > hi) ? d - hi : lo - d;
      if (trk_en && over > int'(excess_max[c])) excess_max[c] = delay_t'(over);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic monitor_report_t predict_report(
    logic                 op,
    logic [CHAN_W-1:0]    ch,
    logic                 sg,
    logic                 g,
    logic                 fr,
    logic                 fg,
    logic [ELAPSED_W-1:0] el
  );
    monitor_report_t r;
    int              c;
    int              acc;
    r = '0;
    r.chan = ch;
    c = int'(ch);
    // channel out of range: state untouched, only the channel is reported
    if (c >= CHANNELS) return r;
    if (op == OP_INIT) begin
      seed_channel(c);
    end else begin
      if (sg || (g && fr && el != '0)) begin
        acc = int'(running[c]) + int'(el);
        running[c] = (acc > int'(DELAY_MAX)) ? DELAY_MAX : delay_t'(acc);
      end
      if (el != '0 && fg && running[c] != '0) begin
        r.taken = 1'b1;
        r.err   = close_sample(c);
      end
    end
    r.latest  = history[c][0];
    r.average = avg[c];
    r.count   = err_cnt[c];
    r.excess  = excess_max[c];
    return r;
  endfunction

  always @(posedge clk) begin
    monitor_report_t want;
    monitor_report_t seen;
    if (rst) begin
      win_len    = 3'd5;
      tol        = '0;
      chk_en     = 1'b0;
      trk_en     = 1'b0;
      init_delay = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        for (int i = 0; i < HISTORY_DEPTH; i++) history[c][i] = '0;
        running[c]    = '0;
        avg[c]        = '0;
        err_cnt[c]    = '0;
        excess_max[c] = '0;
      end
      due_reports.delete();
      mismatches = 0;
      fail_count <= 0;
    end else begin
      // results leaving the block, oldest expectation first
      if (results.valid && results.ready) begin
        seen.chan    = results.out_channel;
        seen.latest  = results.latest_delay;
        seen.average = results.average_delay;
        seen.taken   = results.sample_taken;
        seen.err     = results.deviation_error;
        seen.count   = results.error_count;
        seen.excess  = results.max_excess;
        if (due_reports.size() == 0) begin
          if (mismatches < 10)
            $display("chk: %0t result with nothing outstanding, ch=%0d",
                     $realtime, seen.chan);
          mismatches++;
        end else begin
          want = due_reports.pop_front();
          if (seen !== want) begin
            if (mismatches < 10) begin
              $display({"chk: %0t mismatch exp ch=%0d lat=%0d avg=%0d smp=%0b",
                        " err=%0b cnt=%0d exc=%0d"},
                       $realtime, want.chan, want.latest, want.average, want.taken,
                       want.err, want.count, want.excess);
              $display({"chk:              got ch=%0d lat=%0d avg=%0d smp=%0b",
                        " err=%0b cnt=%0d exc=%0d"},
                       seen.chan, seen.latest, seen.average, seen.taken, seen.err,
                       seen.count, seen.excess);
            end
            mismatches++;
          end
        end
      end
      // items entering the block
      if (items.valid && items.ready)
        due_reports.push_back(predict_report(items.opcode, items.channel,
                                             items.start_green, items.green,
                                             items.feedback_red,
                                             items.feedback_green, items.elapsed));
      // register writes
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_WINDOW_LENGTH:    win_len    = cfg.data[WIN_W-1:0];
          CFG_TOLERANCE:        tol        = cfg.data;
          CFG_ERROR_CHECK_EN:   chk_en     = cfg.data[0];
          CFG_DEVIATION_TRK_EN: trk_en     = cfg.data[0];
          CFG_INITIAL_DELAY:    init_delay = cfg.data;
          default: ;
        endcase
      end
      fail_count <= mismatches;
    end
    pending <= due_reports.size();
  end

endmodule

/* test/start_delay_average_monitor_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// start_delay_average_monitor_tb
// Drives green start sequences, initialisations and stray items into the
// start delay average monitor over several register settings, with random
// gaps on both sides and one long result stall; the checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module start_delay_average_monitor_tb;
  import sdam_pkg::*;

  localparam int IDLE_PCT        = 17;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 40;
  localparam int PHASES          = 7;
  localparam int ITEMS_PER_PHASE = 130;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;
  int   items_sent;
  logic calm;
  logic squeeze_req;
  logic squeezed;

  sdam_item_if   items_if ();
  sdam_result_if results_if ();
  sdam_cfg_if    cfg_if ();

  start_delay_average_monitor u_top (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  start_delay_average_monitor_chk u_chk (
    .clk        (clk),
    .rst        (rst),
    .items      (items_if),
    .results    (results_if),
    .cfg        (cfg_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // result side: random back-pressure, one long hold on request
  initial begin
    int held;
    squeezed = 1'b0;
    results_if.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        results_if.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
      end else begin
        results_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  task automatic offer(logic op, logic [CHAN_W-1:0] ch, logic sg, logic g, logic fr,
                       logic fg, logic [ELAPSED_W-1:0] el);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      items_if.valid <= 1'b0;
      @(posedge clk);
    end
    items_if.valid          <= 1'b1;
    items_if.opcode         <= op;
    items_if.channel        <= ch;
    items_if.start_green    <= sg;
    items_if.green          <= g;
    items_if.feedback_red   <= fr;
    items_if.feedback_green <= fg;
    items_if.elapsed        <= el;
    do @(posedge clk); while (!items_if.ready);
    items_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic apply_setting(logic [WIN_W-1:0] w, delay_t t, logic ec, logic dt,
                               delay_t seed);
    write_reg(CFG_WINDOW_LENGTH, CFG_DATA_W'(w));
    write_reg(CFG_TOLERANCE, t);
    write_reg(CFG_ERROR_CHECK_EN, CFG_DATA_W'(ec));
    write_reg(CFG_DEVIATION_TRK_EN, CFG_DATA_W'(dt));
    write_reg(CFG_INITIAL_DELAY, seed);
    cfg_if.valid <= 1'b0;
  endtask

  // wait for every result, then for the block to go quiet
  task automatic settle();
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // start green, some red feedback, then confirmed green
  task automatic green_cycle(logic [CHAN_W-1:0] ch);
    int   steps;
    int   i;
    int   span;
    span  = ($urandom_range(7) == 0) ? 255 : 40;
    steps = $urandom_range(3);
    offer(OP_UPDATE, ch, 1'b1, 1'($urandom), 1'($urandom), 1'b0,
          ELAPSED_W'($urandom_range(span)));
    for (i = 0; i < steps; i++)
      offer(OP_UPDATE, ch, 1'b0, 1'b1, 1'b1, 1'b0, ELAPSED_W'($urandom_range(span)));
    offer(OP_UPDATE, ch, 1'b0, 1'b1, 1'($urandom), 1'b1,
          ELAPSED_W'($urandom_range(span, 1)));
  endtask

  task automatic stream(int budget);
    int                start;
    int                pick;
    logic [CHAN_W-1:0] ch;
    start = items_sent;
    while (items_sent - start < budget) begin
      pick = $urandom_range(99);
      // a few busy channels so histories fill, others now and then
      ch = ($urandom_range(3) == 0) ? CHAN_W'($urandom_range(31)) : CHAN_W'($urandom_range(3));
      if (pick < 70) begin
        green_cycle(ch);
      end else if (pick < 77) begin
        offer(OP_INIT, ch, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
              ELAPSED_W'($urandom_range(255)));
      end else if (pick < 90) begin
        offer(OP_UPDATE, ch, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
              ELAPSED_W'($urandom_range(255)));
      end else begin
        // start without confirmation, feedback green with no time passing
        offer(OP_UPDATE, ch, 1'b1, 1'b0, 1'b0, 1'b0, ELAPSED_W'($urandom_range(20)));
        offer(OP_UPDATE, ch, 1'b0, 1'b1, 1'b1, 1'b1, 8'd0);
      end
    end
    items_if.valid <= 1'b0;
  endtask

  initial begin
    int ph;
    int i;
    rst                     <= 1'b1;
    items_if.valid          <= 1'b0;
    items_if.opcode         <= OP_UPDATE;
    items_if.channel        <= '0;
    items_if.start_green    <= 1'b0;
    items_if.green          <= 1'b0;
    items_if.feedback_red   <= 1'b0;
    items_if.feedback_green <= 1'b0;
    items_if.elapsed        <= '0;
    cfg_if.valid            <= 1'b0;
    cfg_if.index            <= CFG_WINDOW_LENGTH;
    cfg_if.data             <= '0;
    calm        = 1'b0;
    squeeze_req = 1'b0;
    items_sent  = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed items under the reset settings
    offer(OP_INIT,   5'd0,  1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
    offer(OP_UPDATE, 5'd31, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0);    // start green, no time
    offer(OP_UPDATE, 5'd31, 1'b1, 1'b0, 1'b0, 1'b0, 8'd255);
    offer(OP_UPDATE, 5'd31, 1'b0, 1'b1, 1'b1, 1'b0, 8'd0);    // red feedback, no time
    offer(OP_UPDATE, 5'd31, 1'b0, 1'b1, 1'b1, 1'b0, 8'd255);
    offer(OP_UPDATE, 5'd31, 1'b0, 1'b1, 1'b0, 1'b1, 8'd0);    // green, no time: no sample
    offer(OP_UPDATE, 5'd31, 1'b0, 1'b1, 1'b0, 1'b1, 8'd1);    // sample
    offer(OP_UPDATE, 5'd0,  1'b0, 1'b0, 1'b0, 1'b1, 8'd9);    // nothing running
    offer(OP_UPDATE, 5'd31, 1'b1, 1'b1, 1'b1, 1'b1, 8'd255);
    offer(OP_INIT,   5'd31, 1'b1, 1'b1, 1'b1, 1'b1, 8'd255);
    offer(OP_UPDATE, 5'd5,  1'b0, 1'b1, 1'b0, 1'b0, 8'd7);    // green without red feedback
    for (i = 0; i < 3; i++) begin
      offer(OP_UPDATE, 5'd0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd3);
      offer(OP_UPDATE, 5'd0, 1'b0, 1'b1, 1'b1, 1'b1, 8'd2);
    end
    items_if.valid <= 1'b0;

    for (ph = 1; ph <= PHASES; ph++) begin
      settle();
      case (ph)
        1: apply_setting(3'd5, 15'd0, 1'b1, 1'b1, 15'd0);
        2: apply_setting(3'd1, DELAY_MAX, 1'b1, 1'b1, DELAY_MAX);
        3: apply_setting(3'd0, 15'($urandom_range(3)), 1'b1, 1'b0, 15'd1);
        4: apply_setting(3'd7, 15'($urandom_range(12, 4)), 1'b1, 1'b1, 15'd2);
        5: apply_setting(3'd3, 15'($urandom_range(50)), 1'b0, 1'b1, 15'd3);
        6: apply_setting(3'd2, 15'($urandom_range(30)), 1'b1, 1'b1,
                         15'($urandom_range(32767)));
        default: apply_setting(3'd4, 15'($urandom_range(20)), 1'b1, 1'b1,
                               15'($urandom_range(300)));
      endcase
      // no gaps anywhere for one phase, a long result stall in another
      calm        = (ph == 3);
      squeeze_req = (ph == 4);
      if (ph == 1) begin
        // hold a start long enough for the running delay to saturate
        for (i = 0; i < 130; i++)
          offer(OP_UPDATE, 5'd7, 1'b1, 1'b1, 1'b1, 1'b0, 8'd255);
        offer(OP_UPDATE, 5'd7, 1'b0, 1'b1, 1'b0, 1'b1, 8'd255);
      end
      stream(ITEMS_PER_PHASE);
      calm = 1'b0;
    end

    settle();
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
